// ===== rtl/b3s_pkg.sv =====
package b3s_pkg;

    localparam int PIX_W    = 8;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 1;
    localparam int ROW_W    = 11;
    localparam int VSUM_W   = 10;
    localparam int SUM_W    = 12;
    localparam int NCELL    = 2;

    localparam int MAX_LINE_DEF = 1024;

    localparam int W_MIN = 3;
    localparam int H_MIN = 3;
    localparam int H_MAX = 2046;

    localparam logic [CFG_W-1:0] RST_LINE_WIDTH   = CFG_W'(640);
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = CFG_W'(480);

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_col;

    typedef struct packed {
        logic rep_top;
        logic rep_bot;
    } t_rep;

    typedef struct packed {
        logic [SUM_W-1:0] smoothed;
        logic             end_of_frame;
    } t_res;

    // Vertical 1-2-1 sum of one column, with the outer rows replaced by the
    // middle row at the top and bottom image borders.
    function automatic logic [VSUM_W-1:0] f_vsum(t_col col, t_rep rep);
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] lower;
        upper = rep.rep_top ? col.mid : col.top;
        lower = rep.rep_bot ? col.mid : col.bot;
        return VSUM_W'(upper) + VSUM_W'(lower) + (VSUM_W'(col.mid) << 1);
    endfunction

endpackage

// ===== rtl/b3s_if.sv =====
interface b3s_pix_if;
    import b3s_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             is_padding;

    modport source (output valid, output pixel, output is_padding, input ready);
    modport sink (input valid, input pixel, input is_padding, output ready);
endinterface

interface b3s_res_if;
    import b3s_pkg::*;

    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] smoothed;
    logic             end_of_frame;

    modport source (output valid, output smoothed, output end_of_frame, input ready);
    modport sink (input valid, input smoothed, input end_of_frame, output ready);
endinterface

// ===== rtl/binomial_3x3_smoothing_core.sv =====
// One request per clock unless the skid is full; in-image padding ticks are bubbles.
// A result is registered by the request that completes its window, one row plus one
// pixel after its center pixel arrives, into the output register or the skid stage.
// The two line store banks give one read and one write per cycle, prefetched by column.
// Synchronous active-low reset clears counters, window and handshake state and sets
// the width and height registers to 640 and 480; the line stores are not cleared.
module binomial_3x3_smoothing_core #(
    parameter int MAX_LINE = b3s_pkg::MAX_LINE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    b3s_pix_if.sink                          i_pix,
    b3s_res_if.source                        o_res,
    input  logic                             i_cfg_we,
    input  logic [b3s_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [b3s_pkg::CFG_W-1:0]        i_cfg_data
);
    import b3s_pkg::*;

    localparam int COL_W = $clog2(MAX_LINE);
    localparam int WW    = (CFG_W > $clog2(MAX_LINE + 1)) ? CFG_W : $clog2(MAX_LINE + 1);

    logic [CFG_W-1:0] r_line_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] n_row;

    logic             r_in_ready;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_skid_valid;
    logic             n_skid_valid;
    t_res             r_out;
    t_res             n_out;
    t_res             r_skid;

    logic [WW-1:0]    width_ext;
    logic [WW-1:0]    eff_w;
    logic [WW-1:0]    last_col;
    logic [ROW_W-1:0] eff_h;
    logic [ROW_W-1:0] h_plus1;
    logic             col_last;

    logic             accept;
    logic             bubble;
    logic             tick;
    logic             store_step;
    logic             case_edge;
    logic             case_mid;
    logic             emit;
    logic             out_fire;

    logic [PIX_W-1:0] rd_top;
    logic [PIX_W-1:0] rd_mid;
    logic [PIX_W-1:0] new_pix;
    t_col             new_col;
    t_rep             rep;
    t_col             w_chain [0:NCELL-1];
    logic [VSUM_W-1:0] w_vsum [0:NCELL];
    logic [VSUM_W-1:0] vs_left;
    logic [VSUM_W-1:0] vs_center;
    logic [VSUM_W-1:0] vs_right;
    t_res             res;

    // Effective geometry.
    always_comb begin
        width_ext = WW'(r_line_width);
        if (width_ext < WW'(W_MIN)) begin
            eff_w = WW'(W_MIN);
        end else if (width_ext > WW'(MAX_LINE)) begin
            eff_w = WW'(MAX_LINE);
        end else begin
            eff_w = width_ext;
        end
        if (r_frame_height < ROW_W'(H_MIN)) begin
            eff_h = ROW_W'(H_MIN);
        end else if (r_frame_height > ROW_W'(H_MAX)) begin
            eff_h = ROW_W'(H_MAX);
        end else begin
            eff_h = r_frame_height;
        end
    end

    assign last_col = eff_w - WW'(1);
    assign h_plus1  = eff_h + ROW_W'(1);
    assign col_last = (WW'(r_col) == last_col);

    assign accept     = i_pix.valid && r_in_ready;
    assign bubble     = (r_row < eff_h) && i_pix.is_padding;
    assign tick       = accept && !bubble;
    assign store_step = tick && (r_row <= eff_h);

    // The first column of a row closes the previous-previous row on the old window;
    // every other column closes the pixel one to its left on the shifted window.
    assign case_edge = (r_col == '0) && (r_row >= ROW_W'(2));
    assign case_mid  = (r_col != '0) && (r_row != '0) && (r_row <= eff_h);
    assign emit      = tick && (case_edge || case_mid);

    assign rep.rep_top = case_edge ? (r_row == ROW_W'(2)) : (r_row == ROW_W'(1));
    assign rep.rep_bot = case_edge ? (r_row == h_plus1) : (r_row == eff_h);

    assign new_pix = (r_row < eff_h) ? i_pix.pixel : '0;
    assign new_col = '{top: rd_top, mid: rd_mid, bot: new_pix};

    b3s_line_store #(
        .MAX_LINE (MAX_LINE)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_addr (n_col),
        .i_we      (store_step),
        .i_wr_addr (r_col),
        .i_wr_top  (rd_mid),
        .i_wr_mid  (new_pix),
        .o_top     (rd_top),
        .o_mid     (rd_mid)
    );

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        t_col cell_in;
        if (g == NCELL - 1) begin : g_head
            assign cell_in = new_col;
        end else begin : g_body
            assign cell_in = w_chain[g+1];
        end
        b3s_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (store_step),
            .i_rep   (rep),
            .i_col   (cell_in),
            .o_col   (w_chain[g]),
            .o_vsum  (w_vsum[g])
        );
    end

    assign w_vsum[NCELL] = f_vsum(new_col, rep);

    assign vs_left   = (case_mid && (r_col == COL_W'(1))) ? w_vsum[1] : w_vsum[0];
    assign vs_center = w_vsum[1];
    assign vs_right  = case_mid ? w_vsum[2] : w_vsum[1];

    assign res.smoothed     = SUM_W'(vs_left) + (SUM_W'(vs_center) << 1) + SUM_W'(vs_right);
    assign res.end_of_frame = case_edge && (r_row == h_plus1);

    // Position counters; the line store read address follows the next column.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (!i_rst_n || i_cfg_we) begin
            n_col = '0;
            n_row = '0;
        end else if (tick) begin
            if (r_row >= h_plus1) begin
                n_col = '0;
                n_row = '0;
            end else if (col_last) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // Output register with a skid stage behind it.
    assign out_fire = r_out_valid && o_res.ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        if (r_skid_valid) begin
            if (out_fire) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end
        end else if (emit) begin
            if (!r_out_valid || out_fire) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_skid_valid = 1'b1;
            end
        end else if (out_fire) begin
            n_out_valid = 1'b0;
        end
        if (!i_rst_n) begin
            n_out_valid  = 1'b0;
            n_skid_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col        <= n_col;
        r_row        <= n_row;
        r_out_valid  <= n_out_valid;
        r_skid_valid <= n_skid_valid;
        r_in_ready   <= i_rst_n && !n_skid_valid;
        r_out        <= n_out;
        if (emit && !r_skid_valid && r_out_valid && !out_fire) begin
            r_skid <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= RST_LINE_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LINE_WIDTH: begin
                    r_line_width <= i_cfg_data;
                end
                REG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign i_pix.ready        = r_in_ready;
    assign o_res.valid        = r_out_valid;
    assign o_res.smoothed     = r_out.smoothed;
    assign o_res.end_of_frame = r_out.end_of_frame;

endmodule

// ===== rtl/b3s_cell.sv =====
module b3s_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_shift,
    input  b3s_pkg::t_rep              i_rep,
    input  b3s_pkg::t_col              i_col,
    output b3s_pkg::t_col              o_col,
    output logic [b3s_pkg::VSUM_W-1:0] o_vsum
);
    import b3s_pkg::*;

    t_col r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col  = r_col;
    assign o_vsum = f_vsum(r_col, i_rep);

endmodule

// ===== rtl/b3s_line_store.sv =====
module b3s_line_store #(
    parameter int MAX_LINE = b3s_pkg::MAX_LINE_DEF
) (
    input  logic                        i_clk,
    input  logic [$clog2(MAX_LINE)-1:0] i_rd_addr,
    input  logic                        i_we,
    input  logic [$clog2(MAX_LINE)-1:0] i_wr_addr,
    input  logic [b3s_pkg::PIX_W-1:0]   i_wr_top,
    input  logic [b3s_pkg::PIX_W-1:0]   i_wr_mid,
    output logic [b3s_pkg::PIX_W-1:0]   o_top,
    output logic [b3s_pkg::PIX_W-1:0]   o_mid
);
    import b3s_pkg::*;

    logic [PIX_W-1:0] r_top_mem [0:MAX_LINE-1];
    logic [PIX_W-1:0] r_mid_mem [0:MAX_LINE-1];
    logic [PIX_W-1:0] r_top_rd;
    logic [PIX_W-1:0] r_mid_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_top_mem[i_wr_addr] <= i_wr_top;
        end
        r_top_rd <= r_top_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mid_mem[i_wr_addr] <= i_wr_mid;
        end
        r_mid_rd <= r_mid_mem[i_rd_addr];
    end

    assign o_top = r_top_rd;
    assign o_mid = r_mid_rd;

endmodule

// ===== sim/binomial_3x3_smoothing_core_tb.sv =====
module binomial_3x3_smoothing_core_tb;
    import b3s_pkg::*;

    localparam int MAXL       = MAX_LINE_DEF;
    localparam int SETTLE_CYC = 8;
    localparam int IDLE_MAX   = 12;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    b3s_pix_if pix_if ();
    b3s_res_if res_if ();

    binomial_3x3_smoothing_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predicted state of the filter.
    logic [CFG_W-1:0] mdl_width;
    logic [CFG_W-1:0] mdl_height;
    bit [PIX_W-1:0]   row_mem [0:2*MAXL-1];
    bit [PIX_W-1:0]   taps [0:8];
    int unsigned      col_pos;
    int unsigned      row_pos;
    t_res             smooth_q [$];

    int unsigned err_count;
    int unsigned pixel_reqs;
    int unsigned result_count;
    int unsigned frame_count;
    int unsigned reg_writes;
    int unsigned src_max_gap   = IDLE_MAX;
    int unsigned snk_max_stall = IDLE_MAX;
    int unsigned sink_hold     = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 100) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    function automatic int unsigned clamp(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Rows t, m, b and columns l, cn, rt select the taps of the 1-2-1 x 1-2-1 kernel.
    function automatic logic [SUM_W-1:0] kernel_sum(input int unsigned t, input int unsigned m,
                                                    input int unsigned b, input int unsigned l,
                                                    input int unsigned cn,
                                                    input int unsigned rt);
        int unsigned s;
        s = taps[t*3+l] + taps[t*3+rt] + taps[b*3+l] + taps[b*3+rt];
        s += 2 * (taps[t*3+cn] + taps[b*3+cn] + taps[m*3+l] + taps[m*3+rt]);
        s += 4 * taps[m*3+cn];
        return s[SUM_W-1:0];
    endfunction

    function automatic bit smooth_predict(input logic [PIX_W-1:0] v, input logic pad,
                                          output t_res res);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned k;
        bit [PIX_W-1:0] up;
        bit [PIX_W-1:0] md;
        bit [PIX_W-1:0] nv;
        bit got;
        w = clamp(mdl_width, W_MIN, MAXL);
        h = clamp(mdl_height, H_MIN, H_MAX);
        r = row_pos;
        c = col_pos;
        got = 1'b0;
        res = '0;
        if (c >= w) c = 0;
        if (r > h + 1) r = 0;
        if (r < h && pad) begin
            row_pos = r;
            col_pos = c;
            return 1'b0;
        end
        pixel_reqs++;
        // The right edge of the row two above is finished before the window shifts.
        if (c == 0 && r >= 2) begin
            res.smoothed     = kernel_sum(r == 2 ? 1 : 0, 1, (r - 1 == h) ? 1 : 2, 1, 2, 2);
            res.end_of_frame = (r == h + 1);
            got = 1'b1;
        end
        if (r <= h) begin
            up = row_mem[c];
            md = row_mem[MAXL + c];
            nv = (r < h) ? v : '0;
            row_mem[c]        = md;
            row_mem[MAXL + c] = nv;
            for (k = 0; k < 3; k++) begin
                taps[k*3]   = taps[k*3+1];
                taps[k*3+1] = taps[k*3+2];
            end
            taps[2] = up;
            taps[5] = md;
            taps[8] = nv;
            if (c >= 1 && r >= 1) begin
                res.smoothed     = kernel_sum(r == 1 ? 1 : 0, 1, (r == h) ? 1 : 2,
                                              c == 1 ? 1 : 0, 1, 2);
                res.end_of_frame = 1'b0;
                got = 1'b1;
            end
        end
        if (r >= h + 1) begin
            r = 0;
            c = 0;
        end else begin
            c++;
            if (c >= w) begin
                c = 0;
                r++;
            end
        end
        row_pos = r;
        col_pos = c;
        return got;
    endfunction

    // Results are checked before the request of the same edge is predicted.
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            mdl_width  = RST_LINE_WIDTH;
            mdl_height = RST_FRAME_HEIGHT;
            foreach (taps[k]) taps[k] = '0;
            row_pos = 0;
            col_pos = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                result_count++;
                if (smooth_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              result_count));
                end else begin
                    want = smooth_q.pop_front();
                    if (res_if.smoothed !== want.smoothed) begin
                        report_mismatch($sformatf("result %0d smoothed %0d, expected %0d",
                                                  result_count, res_if.smoothed,
                                                  want.smoothed));
                    end
                    if (res_if.end_of_frame !== want.end_of_frame) begin
                        report_mismatch($sformatf("result %0d end_of_frame %b, expected %b",
                                                  result_count, res_if.end_of_frame,
                                                  want.end_of_frame));
                    end
                    if (want.end_of_frame) frame_count++;
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == REG_LINE_WIDTH) begin
                    mdl_width = i_cfg_data;
                end else if (i_cfg_index == REG_FRAME_HEIGHT) begin
                    mdl_height = i_cfg_data;
                end
                row_pos = 0;
                col_pos = 0;
                reg_writes++;
            end
            if (pix_if.valid && pix_if.ready) begin
                if (smooth_predict(pix_if.pixel, pix_if.is_padding, want)) begin
                    smooth_q.push_back(want);
                end
            end
        end
    end

    // Result receiver with random stalls and an optional long hold-off.
    initial begin
        int unsigned stall;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (sink_hold != 0) begin
                res_if.ready <= 1'b0;
                repeat (sink_hold) @(negedge i_clk);
                sink_hold = 0;
            end
            stall = $urandom_range(0, snk_max_stall);
            if (stall != 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
        end
    end

    task automatic push_pixel(input logic [PIX_W-1:0] v, input logic pad);
        int unsigned gap;
        gap = $urandom_range(0, src_max_gap);
        @(negedge i_clk);
        if (gap != 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_if.valid      <= 1'b1;
        pix_if.pixel      <= v;
        pix_if.is_padding <= pad;
        do @(posedge i_clk); while (pix_if.ready !== 1'b1);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        pix_if.valid <= 1'b0;
        while (smooth_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Sends up to stop_at pixel and flush requests of a w by h frame, plus padding bubbles.
    task automatic run_frame(input int unsigned w, input int unsigned h,
                             input int unsigned bubble_pct, input int unsigned stop_at);
        int unsigned n_pix;
        int unsigned k;
        n_pix = w * h;
        for (k = 0; k < n_pix + w + 1 && k < stop_at; k++) begin
            if (k < n_pix) begin
                while ($urandom_range(0, 99) < bubble_pct) begin
                    push_pixel(PIX_W'($urandom_range(0, 255)), 1'b1);
                end
                if ($urandom_range(0, 3) == 0) begin
                    push_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00, 1'b0);
                end else begin
                    push_pixel(PIX_W'($urandom_range(0, 255)), 1'b0);
                end
            end else begin
                push_pixel(PIX_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Part of a frame at the 640 by 480 reset size, across the first row wrap.
    task automatic test_reset_defaults();
        run_frame(RST_LINE_WIDTH, RST_FRAME_HEIGHT, 0, RST_LINE_WIDTH + 5);
        wait_idle();
    endtask

    task automatic test_directed_borders();
        int unsigned k;
        // Undersized registers clamp to a 3 by 3 frame; all-white gives the largest sum.
        write_reg(REG_LINE_WIDTH, 2);
        write_reg(REG_FRAME_HEIGHT, 0);
        for (k = 0; k < 9; k++) begin
            if (k == 3) push_pixel(8'h00, 1'b1);
            push_pixel(8'hFF, 1'b0);
        end
        push_pixel(8'h5A, 1'b0);
        push_pixel(8'hA5, 1'b1);
        push_pixel(8'h3C, 1'b0);
        push_pixel(8'hC3, 1'b1);
        wait_idle();
        write_reg(REG_LINE_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 3);
        for (k = 0; k < 9; k++) push_pixel((k % 2) ? 8'hFF : 8'h00, 1'b0);
        repeat (4) push_pixel(8'hFF, 1'b1);
        wait_idle();
    endtask

    // A register write in the middle of a frame starts the next frame from its first pixel.
    task automatic test_config_restart();
        write_reg(REG_LINE_WIDTH, 5);
        write_reg(REG_FRAME_HEIGHT, 4);
        run_frame(5, 4, 10, 8);
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, 4);
        run_frame(5, 4, 10, 5 * 4 + 6);
        wait_idle();
    endtask

    task automatic test_backpressure();
        write_reg(REG_LINE_WIDTH, 8);
        write_reg(REG_FRAME_HEIGHT, 5);
        src_max_gap = 0;
        sink_hold   = 300;
        run_frame(8, 5, 0, 30);
        wait_idle();
        repeat (10) push_pixel(PIX_W'($urandom_range(0, 255)), 1'b0);
        repeat (9) push_pixel(PIX_W'($urandom_range(0, 255)), 1'b1);
        wait_idle();
        src_max_gap = IDLE_MAX;
    endtask

    // Largest sizes are run only in part: the widest row and the first rows of tall frames.
    task automatic test_extreme_sizes();
        write_reg(REG_LINE_WIDTH, 2047);
        write_reg(REG_FRAME_HEIGHT, 3);
        run_frame(MAXL, 3, 5, MAXL + 40);
        wait_idle();
        write_reg(REG_LINE_WIDTH, 0);
        write_reg(REG_FRAME_HEIGHT, 1024);
        run_frame(3, 1024, 5, 30);
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, 2047);
        run_frame(3, H_MAX, 5, 30);
        wait_idle();
    endtask

    task automatic test_random_frames();
        int unsigned goal;
        int unsigned w_reg;
        int unsigned h_reg;
        int unsigned w;
        int unsigned h;
        int unsigned frame_len;
        int unsigned stop_at;
        bit          need_cfg;
        goal     = pixel_reqs + 300;
        need_cfg = 1'b1;
        w        = 3;
        h        = 3;
        while (pixel_reqs < goal) begin
            if (need_cfg || $urandom_range(0, 3) == 0) begin
                wait_idle();
                case ($urandom_range(0, 9))
                    0:       w_reg = $urandom_range(0, 2);
                    1:       w_reg = $urandom_range(13, 64);
                    default: w_reg = $urandom_range(3, 12);
                endcase
                h_reg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
                write_reg(REG_LINE_WIDTH, w_reg);
                write_reg(REG_FRAME_HEIGHT, h_reg);
                w = clamp(w_reg, W_MIN, MAXL);
                h = clamp(h_reg, H_MIN, H_MAX);
            end
            src_max_gap   = ($urandom_range(0, 4) == 0) ? 0 : IDLE_MAX;
            snk_max_stall = ($urandom_range(0, 4) == 0) ? 0 : IDLE_MAX;
            frame_len = w * h + w + 1;
            stop_at   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, frame_len - 1)
                                                    : frame_len;
            run_frame(w, h, $urandom_range(0, 1) ? 0 : 15, stop_at);
            need_cfg = (stop_at != frame_len);
        end
        src_max_gap   = IDLE_MAX;
        snk_max_stall = IDLE_MAX;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        pix_if.valid      = 1'b0;
        pix_if.pixel      = '0;
        pix_if.is_padding = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_borders();
        test_config_restart();
        test_backpressure();
        test_extreme_sizes();
        test_random_frames();

        wait_idle();
        repeat (2 * SETTLE_CYC) @(negedge i_clk);
        if (smooth_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived", smooth_q.size()));
        end
        $display("Checked %0d results from %0d pixel and flush requests over %0d frames.",
                 result_count, pixel_reqs, frame_count);
        $display("Ran %0d register writes, clamped and extreme sizes, stalls on both sides.",
                 reg_writes);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
